### rtl/ihfp_pkg.sv
// ----------------------------------------------------------------------------
// ihfp_pkg
// shared types and codes of the image header field parser
// ----------------------------------------------------------------------------
package ihfp_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int GROUP_W = 14;

  // result status codes
  localparam logic [1:0] STATUS_BUSY = 2'd0;
  localparam logic [1:0] STATUS_DONE = 2'd1;
  localparam logic [1:0] STATUS_ERR  = 2'd2;

  // field kinds assigned to a tag byte
  localparam logic [2:0] KIND_WIDTH  = 3'd0;
  localparam logic [2:0] KIND_HEIGHT = 3'd1;
  localparam logic [2:0] KIND_COMP   = 3'd2;
  localparam logic [2:0] KIND_FRAME  = 3'd3;
  localparam logic [2:0] KIND_DELIM  = 3'd4;
  localparam logic [2:0] KIND_PLAIN  = 3'd5;

  localparam logic [7:0] TAG_WIDTH  = 8'h08;
  localparam logic [7:0] TAG_HEIGHT = 8'h10;
  localparam logic [7:0] TAG_COMP   = 8'h18;
  localparam logic [7:0] TAG_FRAME  = 8'h20;
  localparam logic [2:0] WIRE_DELIM = 3'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       cont;
    logic       tag_bad;
    logic [2:0] kind;
  } ihfp_item_t;

  typedef struct packed {
    logic [3:0]         pad;
    logic [GROUP_W-1:0] group_cols;
    logic [GROUP_W-1:0] group_rows;
    logic [4:0]         max_vertical_factor;
    logic [4:0]         max_horizontal_factor;
    logic [31:0]        frame_layout;
    logic [2:0]         component_count;
    logic               format_version;
    logic [15:0]        image_height;
    logic [15:0]        image_width;
    logic [1:0]         parse_status;
  } ihfp_result_t;

  localparam int RESULT_W = $bits(ihfp_result_t);

endpackage

### rtl/ihfp_front.sv
// ----------------------------------------------------------------------------
// ihfp_front
// accepts stream bytes, classifies them and queues them for the parser
// ----------------------------------------------------------------------------
module ihfp_front import ihfp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // stream_byte
  input  logic [0:0] s_tuser,   // new_stream
  output logic       q_valid,
  output ihfp_item_t q_item,
  input  logic       q_pop
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  ihfp_item_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  ihfp_item_t in_item;
  logic push;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  always_comb begin
    in_item.data = s_tdata;
    in_item.restart = s_tuser[0];
    in_item.cont = s_tdata[7];
    in_item.tag_bad = s_tdata[7] || s_tdata[2] || s_tdata[0] || (s_tdata <= 8'h02);
    if (s_tdata == TAG_WIDTH) begin
      in_item.kind = KIND_WIDTH;
    end else if (s_tdata == TAG_HEIGHT) begin
      in_item.kind = KIND_HEIGHT;
    end else if (s_tdata == TAG_COMP) begin
      in_item.kind = KIND_COMP;
    end else if (s_tdata == TAG_FRAME) begin
      in_item.kind = KIND_FRAME;
    end else if (s_tdata[2:0] == WIRE_DELIM) begin
      in_item.kind = KIND_DELIM;
    end else begin
      in_item.kind = KIND_PLAIN;
    end
  end

  assign s_tready = (count != CntW'(DEPTH));
  assign push = s_tvalid && s_tready;
  assign q_valid = (count != '0);
  assign q_item = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + CntW'(1);
    end else if (!push && q_pop) begin
      count_next = count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (q_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

### rtl/ihfp_divider.sv
// ----------------------------------------------------------------------------
// ihfp_divider
// two-lane restoring divider for the rounded-up block-group counts
// ----------------------------------------------------------------------------
module ihfp_divider import ihfp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        num_a,
  input  logic [4:0]         den_a,
  input  logic [15:0]        num_b,
  input  logic [4:0]         den_b,
  output logic               done,
  output logic [GROUP_W-1:0] quo_a,
  output logic [GROUP_W-1:0] quo_b
);

  localparam int CntW = $clog2(GROUP_W + 1);

  logic               busy;
  logic [CntW-1:0]    cnt;
  logic [GROUP_W-1:0] qs [2];
  logic [4:0]         rem [2];
  logic [4:0]         den [2];
  logic [15:0]        num_in [2];
  logic [4:0]         den_in [2];
  logic [GROUP_W-1:0] seed [2];
  logic [GROUP_W-1:0] qs_next [2];
  logic [4:0]         rem_next [2];

  assign num_in[0] = num_a;
  assign num_in[1] = num_b;
  assign den_in[0] = den_a;
  assign den_in[1] = den_b;

  // ceil(n / (8 d)) = ceil(ceil(n / 8) / d)
  always_comb begin
    logic [16:0] n8;
    logic [14:0] s;
    logic [5:0]  r2;
    logic        ge;
    for (int l = 0; l < 2; l++) begin
      n8 = {1'b0, num_in[l]} + 17'd7;
      s = {1'b0, n8[16:3]} + {10'b0, den_in[l]} - 15'd1;
      seed[l] = s[GROUP_W-1:0];
      r2 = {rem[l], qs[l][GROUP_W-1]};
      ge = (r2 >= {1'b0, den[l]});
      qs_next[l] = {qs[l][GROUP_W-2:0], ge};
      rem_next[l] = ge ? 5'(r2 - {1'b0, den[l]}) : r2[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + CntW'(1);
        if (cnt == CntW'(GROUP_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (start) begin
        qs[l] <= seed[l];
        rem[l] <= '0;
        den[l] <= den_in[l];
      end else if (busy) begin
        qs[l] <= qs_next[l];
        rem[l] <= rem_next[l];
      end
    end
  end

  assign quo_a = qs[0];
  assign quo_b = qs[1];

endmodule

### rtl/ihfp_back.sv
// ----------------------------------------------------------------------------
// ihfp_back
// header parsing state machine, geometry and result register
// ----------------------------------------------------------------------------
module ihfp_back import ihfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_valid,
  input  ihfp_item_t            q_item,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [RESULT_W-1:0]   m_tdata
);

  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER        = 1'b1;

  localparam logic [2:0] PH_MARK = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_TAG  = 3'd2;
  localparam logic [2:0] PH_VAL  = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;
  localparam logic [2:0] PH_ERR  = 3'd6;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DLOAD = 2'd1;
  localparam logic [1:0] ST_DWAIT = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam logic [3:0] VGROUP_LIMIT = 4'd9;

  logic [31:0] stream_length;
  logic [7:0]  marker;

  logic [1:0]  ctl;
  logic [1:0]  ctl_next;

  logic [2:0]  phase, phase_next, base_phase;
  logic [31:0] pos, pos_next, base_pos;
  logic [31:0] seg_end, seg_next, base_seg;
  logic [31:0] acc_lo, acc_lo_next, base_acc_lo;
  logic        acc_hi, acc_hi_next, base_acc_hi;
  logic [3:0]  vgroup, vgroup_next, base_vgroup;
  logic [2:0]  kind, kind_next, base_kind;
  logic [31:0] skip_rem, skip_next, base_skip;
  logic [15:0] width_val, width_next, base_width;
  logic [15:0] height_val, height_next, base_height;
  logic [7:0]  comp, comp_next, base_comp;
  logic [31:0] frame_val, frame_next, base_frame;
  logic        frame_abs, fabs_next, base_fabs;

  logic [31:0] npos;
  logic [31:0] room;
  logic [5:0]  vsh;
  logic [31:0] v_lo;
  logic        v_hi;
  logic        hi_add;
  logic [32:0] len_sum;
  logic        range_err;
  logic        end_field;
  logic        fin_err;

  logic               ver;
  logic [2:0]         cnt;
  logic [4:0]         max_h;
  logic [4:0]         max_v;
  logic [GROUP_W-1:0] res_rows;
  logic [GROUP_W-1:0] res_cols;
  ihfp_result_t       done_res;
  ihfp_result_t       out_res;
  ihfp_result_t       load_res;
  logic               out_free;
  logic               load;

  logic               div_start;
  logic               div_done;
  logic [GROUP_W-1:0] quo_rows;
  logic [GROUP_W-1:0] quo_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_length <= '0;
      marker <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STREAM_LENGTH: stream_length <= cfg_data;
        CFG_MARKER: marker <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // parser step for the byte at the queue head
  always_comb begin
    base_phase  = q_item.restart ? PH_MARK : phase;
    base_pos    = q_item.restart ? '0 : pos;
    base_seg    = q_item.restart ? '0 : seg_end;
    base_acc_lo = q_item.restart ? '0 : acc_lo;
    base_acc_hi = q_item.restart ? 1'b0 : acc_hi;
    base_vgroup = q_item.restart ? '0 : vgroup;
    base_kind   = q_item.restart ? KIND_WIDTH : kind;
    base_skip   = q_item.restart ? '0 : skip_rem;
    base_width  = q_item.restart ? '0 : width_val;
    base_height = q_item.restart ? '0 : height_val;
    base_comp   = q_item.restart ? 8'hff : comp;
    base_frame  = q_item.restart ? 32'hff : frame_val;
    base_fabs   = q_item.restart ? 1'b1 : frame_abs;

    phase_next  = base_phase;
    pos_next    = base_pos;
    seg_next    = base_seg;
    acc_lo_next = base_acc_lo;
    acc_hi_next = base_acc_hi;
    vgroup_next = base_vgroup;
    kind_next   = base_kind;
    skip_next   = base_skip;
    width_next  = base_width;
    height_next = base_height;
    comp_next   = base_comp;
    frame_next  = base_frame;
    fabs_next   = base_fabs;
    end_field   = 1'b0;

    npos = base_pos + 32'd1;
    room = base_seg - npos;
    vsh = {2'b00, base_vgroup} * 6'd7;
    v_lo = base_acc_lo | ({25'b0, q_item.data[6:0]} << vsh);
    if (base_vgroup == 4'd4) begin
      hi_add = |q_item.data[6:4];
    end else if (base_vgroup > 4'd4) begin
      hi_add = |q_item.data[6:0];
    end else begin
      hi_add = 1'b0;
    end
    v_hi = base_acc_hi | hi_add;
    len_sum = {1'b0, npos} + {1'b0, v_lo};

    if (base_phase == PH_MARK || base_phase == PH_LEN) begin
      range_err = (base_pos >= stream_length);
    end else begin
      range_err = (base_pos >= base_seg);
    end

    if (base_phase != PH_DONE && base_phase != PH_ERR) begin
      if (range_err) begin
        phase_next = PH_ERR;
      end else begin
        pos_next = npos;
        case (base_phase)
          PH_MARK: begin
            if (q_item.data != marker) begin
              phase_next = PH_ERR;
            end else begin
              acc_lo_next = '0;
              acc_hi_next = 1'b0;
              vgroup_next = '0;
              phase_next = PH_LEN;
            end
          end
          PH_LEN, PH_VAL: begin
            if (base_vgroup == VGROUP_LIMIT) begin
              phase_next = PH_ERR;
            end else begin
              acc_lo_next = v_lo;
              acc_hi_next = v_hi;
              vgroup_next = base_vgroup + 4'd1;
              if (!q_item.cont) begin
                if (base_phase == PH_LEN) begin
                  if (v_hi || (len_sum > {1'b0, stream_length})) begin
                    phase_next = PH_ERR;
                  end else begin
                    seg_next = len_sum[31:0];
                    end_field = 1'b1;
                  end
                end else begin
                  case (base_kind)
                    KIND_WIDTH: begin
                      if (v_hi || (|v_lo[31:16])) begin
                        phase_next = PH_ERR;
                      end else begin
                        width_next = v_lo[15:0];
                        end_field = 1'b1;
                      end
                    end
                    KIND_HEIGHT: begin
                      if (v_hi || (|v_lo[31:16])) begin
                        phase_next = PH_ERR;
                      end else begin
                        height_next = v_lo[15:0];
                        end_field = 1'b1;
                      end
                    end
                    KIND_COMP: begin
                      if (v_hi || (|v_lo[31:8])) begin
                        phase_next = PH_ERR;
                      end else begin
                        comp_next = v_lo[7:0];
                        end_field = 1'b1;
                      end
                    end
                    KIND_FRAME: begin
                      frame_next = v_lo;
                      fabs_next = !v_hi && (v_lo == 32'hff);
                      end_field = 1'b1;
                    end
                    KIND_DELIM: begin
                      if (v_hi || (v_lo > room)) begin
                        phase_next = PH_ERR;
                      end else if (v_lo != '0) begin
                        skip_next = v_lo;
                        phase_next = PH_SKIP;
                      end else begin
                        end_field = 1'b1;
                      end
                    end
                    default: end_field = 1'b1;
                  endcase
                end
              end
            end
          end
          PH_TAG: begin
            if (q_item.tag_bad) begin
              phase_next = PH_ERR;
            end else if ((q_item.kind == KIND_WIDTH && base_width != '0) ||
                         (q_item.kind == KIND_HEIGHT && base_height != '0) ||
                         (q_item.kind == KIND_COMP && base_comp != 8'hff) ||
                         (q_item.kind == KIND_FRAME && !base_fabs)) begin
              phase_next = PH_ERR;
            end else begin
              kind_next = q_item.kind;
              acc_lo_next = '0;
              acc_hi_next = 1'b0;
              vgroup_next = '0;
              phase_next = PH_VAL;
            end
          end
          PH_SKIP: begin
            skip_next = base_skip - 32'd1;
            if (skip_next == '0) begin
              end_field = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    // segment end: validate version, frame code and sizes
    fin_err = (|comp_next[7:3]) || fabs_next ||
              (!comp_next[2] && (width_next == '0 || height_next == '0));
    if (end_field) begin
      if (npos == seg_next) begin
        phase_next = fin_err ? PH_ERR : PH_DONE;
      end else begin
        phase_next = PH_TAG;
      end
    end
  end

  // sampling maxima from the stored header
  always_comb begin
    logic [4:0] nv;
    logic [4:0] nh;
    ver = comp[2];
    cnt = ver ? 3'd0 : ({1'b0, comp[1:0]} + 3'd1);
    max_h = 5'd1;
    max_v = 5'd1;
    for (int i = 0; i < 4; i++) begin
      nv = {1'b0, frame_val[8*i +: 4]} + 5'd1;
      nh = {1'b0, frame_val[8*i+4 +: 4]} + 5'd1;
      if (!ver && (2'(i) <= comp[1:0])) begin
        if (nv > max_v) begin
          max_v = nv;
        end
        if (nh > max_h) begin
          max_h = nh;
        end
      end
    end
  end

  always_comb begin
    done_res = '0;
    done_res.parse_status = STATUS_DONE;
    done_res.image_width = width_val;
    done_res.image_height = height_val;
    done_res.format_version = ver;
    done_res.component_count = cnt;
    done_res.frame_layout = frame_val;
    done_res.max_horizontal_factor = max_h;
    done_res.max_vertical_factor = max_v;
    done_res.group_rows = res_rows;
    done_res.group_cols = res_cols;
  end

  assign out_free = !m_tvalid || m_tready;
  assign q_pop = q_valid && (ctl == ST_RUN) && out_free;
  assign div_start = (ctl == ST_DLOAD);

  always_comb begin
    load = 1'b0;
    load_res = '0;
    ctl_next = ctl;
    case (ctl)
      ST_RUN: begin
        if (q_pop) begin
          if (phase_next == PH_ERR) begin
            load = 1'b1;
            load_res.parse_status = STATUS_ERR;
          end else if (phase_next == PH_DONE) begin
            if (base_phase == PH_DONE) begin
              load = 1'b1;
              load_res = done_res;
            end else begin
              ctl_next = ST_DLOAD;
            end
          end else begin
            load = 1'b1;
            load_res.parse_status = STATUS_BUSY;
          end
        end
      end
      ST_DLOAD: ctl_next = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          ctl_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          load = 1'b1;
          load_res = done_res;
          ctl_next = ST_RUN;
        end
      end
      default: ctl_next = ST_RUN;
    endcase
  end

  ihfp_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_a (height_val),
    .den_a (max_v),
    .num_b (width_val),
    .den_b (max_h),
    .done  (div_done),
    .quo_a (quo_rows),
    .quo_b (quo_cols)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= ST_RUN;
      m_tvalid <= 1'b0;
      phase <= PH_MARK;
      pos <= '0;
      seg_end <= '0;
      acc_lo <= '0;
      acc_hi <= 1'b0;
      vgroup <= '0;
      kind <= KIND_WIDTH;
      skip_rem <= '0;
      width_val <= '0;
      height_val <= '0;
      comp <= 8'hff;
      frame_val <= 32'hff;
      frame_abs <= 1'b1;
    end else begin
      ctl <= ctl_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (q_pop) begin
        phase <= phase_next;
        pos <= pos_next;
        seg_end <= seg_next;
        acc_lo <= acc_lo_next;
        acc_hi <= acc_hi_next;
        vgroup <= vgroup_next;
        kind <= kind_next;
        skip_rem <= skip_next;
        width_val <= width_next;
        height_val <= height_next;
        comp <= comp_next;
        frame_val <= frame_next;
        frame_abs <= fabs_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
    if (ctl == ST_DWAIT && div_done) begin
      res_rows <= quo_rows;
      res_cols <= quo_cols;
    end
  end

  assign m_tdata = out_res;

endmodule

### rtl/image_header_field_parser.sv
// ----------------------------------------------------------------------------
// image_header_field_parser
// byte-serial parser of a tagged, base-128 coded image header segment
// ----------------------------------------------------------------------------
// path: an accepted byte is queued, parsed from the queue head and its result
//   registered, after the 14-step group divider for a byte ending a valid header
// throughput: one byte per cycle while results are taken and no division runs
// reset: synchronous; clears the queue, parse state and the result valid flag,
//   sets stream_length to 0 and header_marker_byte to 10
// ----------------------------------------------------------------------------
module image_header_field_parser import ihfp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // stream_byte
  input  logic [0:0]            s_tuser,   // new_stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // parse_status, image_width, image_height, format_version, component_count,
  // frame_layout, max_horizontal_factor, max_vertical_factor, group_rows,
  // group_cols, zero fill
  output logic [RESULT_W-1:0]   m_tdata
);

  logic         q_valid;
  logic         q_pop;
  ihfp_item_t   q_item;
  ihfp_result_t mon_res;

  ihfp_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  ihfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  assign mon_res = m_tdata;

  a_pop_from_filled: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (mon_res.parse_status == STATUS_BUSY ||
                  mon_res.parse_status == STATUS_DONE ||
                  mon_res.parse_status == STATUS_ERR))
    else $error("undefined status code");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && mon_res.parse_status != STATUS_DONE) |->
      (m_tdata[RESULT_W-1:2] == '0))
    else $error("payload not cleared on busy or error result");

  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && mon_res.parse_status == STATUS_DONE) |->
      (mon_res.max_horizontal_factor != 5'd0 && mon_res.max_vertical_factor != 5'd0 &&
       mon_res.max_horizontal_factor <= 5'd16 && mon_res.max_vertical_factor <= 5'd16))
    else $error("sampling maximum out of range");

endmodule

### sim/tb_image_header_field_parser.sv
// ----------------------------------------------------------------------------
// tb_image_header_field_parser
// self-checking bench: drives header byte streams through the parser and
// compares every result transfer against a cycle-free model of the parse
// rules; valid, malformed and truncated headers under several register
// settings, with random stalls on both stream sides
// ----------------------------------------------------------------------------
import ihfp_pkg::*;

localparam logic [CFG_IDX_W-1:0] REG_STREAM_LENGTH = CFG_IDX_W'(0);
localparam logic [CFG_IDX_W-1:0] REG_MARKER        = CFG_IDX_W'(1);

typedef enum logic [2:0] {
  ST_MARKER, ST_LENGTH, ST_TAG, ST_VALUE, ST_SKIP, ST_DONE, ST_ERROR
} parse_state_t;

class header_result_board;
  logic [31:0]  stream_len;
  logic [7:0]   marker;
  parse_state_t st;
  logic [31:0]  pos_cnt;
  logic [31:0]  seg_end;
  logic [63:0]  acc;
  int unsigned  acc_shift;
  logic [7:0]   tag;
  logic [31:0]  skip_left;
  logic [31:0]  width_val;
  logic [31:0]  height_val;
  logic [7:0]   comp_val;
  logic [31:0]  frame_val;
  bit           frame_absent;
  ihfp_result_t expected_results[$];
  int unsigned  errors;
  int unsigned  checked;
  int unsigned  n_done;
  int unsigned  n_err;

  function new();
    stream_len = '0;
    marker = 8'h0A;
    errors = 0;
    checked = 0;
    n_done = 0;
    n_err = 0;
    clear_parse();
  endfunction

  function void clear_parse();
    st = ST_MARKER;
    pos_cnt = '0;
    seg_end = '0;
    acc = '0;
    acc_shift = 0;
    tag = '0;
    skip_left = '0;
    width_val = '0;
    height_val = '0;
    comp_val = 8'hFF;
    frame_val = 32'hFF;
    frame_absent = 1'b1;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    if (idx == REG_STREAM_LENGTH) stream_len = val;
    else if (idx == REG_MARKER) marker = val[7:0];
  endfunction

  function void close_segment();
    int unsigned ver;
    ver = comp_val >> 2;
    if (ver > 1 || frame_absent || (ver != 1 && (width_val == 0 || height_val == 0)))
      st = ST_ERROR;
    else
      st = ST_DONE;
  endfunction

  function void end_field(logic [31:0] npos);
    if (npos == seg_end) close_segment();
    else st = ST_TAG;
  endfunction

  function void end_value(logic [31:0] npos);
    case (tag)
      TAG_WIDTH: begin
        if (acc > 64'hFFFF) begin
          st = ST_ERROR;
          return;
        end
        width_val = acc[31:0];
      end
      TAG_HEIGHT: begin
        if (acc > 64'hFFFF) begin
          st = ST_ERROR;
          return;
        end
        height_val = acc[31:0];
      end
      TAG_COMP: begin
        if (acc > 64'hFF) begin
          st = ST_ERROR;
          return;
        end
        comp_val = acc[7:0];
      end
      TAG_FRAME: begin
        frame_val = acc[31:0];
        frame_absent = (acc == 64'hFF);
      end
      default: begin
        if (tag[2:0] == WIRE_DELIM) begin
          if (acc > {32'd0, seg_end - npos}) begin
            st = ST_ERROR;
            return;
          end
          if (acc != 0) begin
            skip_left = acc[31:0];
            st = ST_SKIP;
            return;
          end
        end
      end
    endcase
    end_field(npos);
  endfunction

  function ihfp_result_t predict();
    ihfp_result_t r;
    int unsigned ver, cnt, mh, mv, fc, fv, fh;
    r = '0;
    if (st == ST_ERROR) begin
      r.parse_status = STATUS_ERR;
    end else if (st == ST_DONE) begin
      ver = comp_val >> 2;
      cnt = 0;
      mh = 1;
      mv = 1;
      fc = frame_val;
      if (ver == 0) begin
        cnt = comp_val[1:0] + 1;
        for (int i = 0; i < cnt; i++) begin
          fv = (fc & 15) + 1;
          fc = fc >> 4;
          fh = (fc & 15) + 1;
          fc = fc >> 4;
          if (fv > mv) mv = fv;
          if (fh > mh) mh = fh;
        end
      end
      r.parse_status = STATUS_DONE;
      r.image_width = width_val[15:0];
      r.image_height = height_val[15:0];
      r.format_version = ver[0];
      r.component_count = cnt[2:0];
      r.frame_layout = frame_val;
      r.max_horizontal_factor = mh[4:0];
      r.max_vertical_factor = mv[4:0];
      r.group_rows = GROUP_W'((height_val + 8 * mv - 1) / (8 * mv));
      r.group_cols = GROUP_W'((width_val + 8 * mh - 1) / (8 * mh));
    end
    return r;
  endfunction

  function void note_byte(logic [7:0] b, logic restart);
    logic [31:0] npos;
    logic [63:0] grp;
    logic [63:0] len;
    if (restart) clear_parse();
    if (st != ST_DONE && st != ST_ERROR) begin
      if (st == ST_MARKER || st == ST_LENGTH) begin
        if (pos_cnt >= stream_len) st = ST_ERROR;
      end else if (pos_cnt >= seg_end) begin
        st = ST_ERROR;
      end
      if (st != ST_ERROR) begin
        npos = pos_cnt + 1;
        pos_cnt = npos;
        case (st)
          ST_MARKER: begin
            if (b != marker) begin
              st = ST_ERROR;
            end else begin
              acc = '0;
              acc_shift = 0;
              st = ST_LENGTH;
            end
          end
          ST_LENGTH, ST_VALUE: begin
            if (acc_shift > 57) begin
              st = ST_ERROR;
            end else begin
              grp = {57'd0, b[6:0]};
              acc = acc | (grp << acc_shift);
              acc_shift += 7;
              if (!b[7]) begin
                if (st == ST_LENGTH) begin
                  len = {32'd0, stream_len};
                  if (acc > len || {32'd0, npos} > len - acc) begin
                    st = ST_ERROR;
                  end else begin
                    seg_end = npos + acc[31:0];
                    end_field(npos);
                  end
                end else begin
                  end_value(npos);
                end
              end
            end
          end
          ST_TAG: begin
            if (b[7] || (b & 8'h05) != 0 || b <= 8'h02) begin
              st = ST_ERROR;
            end else if ((b == TAG_WIDTH && width_val != 0) ||
                         (b == TAG_HEIGHT && height_val != 0) ||
                         (b == TAG_COMP && comp_val != 8'hFF) ||
                         (b == TAG_FRAME && !frame_absent)) begin
              st = ST_ERROR;
            end else begin
              tag = b;
              acc = '0;
              acc_shift = 0;
              st = ST_VALUE;
            end
          end
          ST_SKIP: begin
            skip_left = skip_left - 1;
            if (skip_left == 0) end_field(npos);
          end
          default: ;
        endcase
      end
    end
    expected_results.push_back(predict());
  endfunction

  function void show(string label, ihfp_result_t r);
    $display("%s st=%0d w=%0d h=%0d ver=%0d cnt=%0d frame=%h mh=%0d mv=%0d rows=%0d cols=%0d",
             label, r.parse_status, r.image_width, r.image_height, r.format_version,
             r.component_count, r.frame_layout, r.max_horizontal_factor,
             r.max_vertical_factor, r.group_rows, r.group_cols);
  endfunction

  function void check_result(logic [RESULT_W-1:0] raw);
    ihfp_result_t got, want;
    got = raw;
    checked++;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("result transfer %h with nothing pending", raw);
      return;
    end
    want = expected_results.pop_front();
    if (want.parse_status == STATUS_DONE) n_done++;
    else if (want.parse_status == STATUS_ERR) n_err++;
    if (got.parse_status != want.parse_status ||
        got.image_width != want.image_width ||
        got.image_height != want.image_height ||
        got.format_version != want.format_version ||
        got.component_count != want.component_count ||
        got.frame_layout != want.frame_layout ||
        got.max_horizontal_factor != want.max_horizontal_factor ||
        got.max_vertical_factor != want.max_vertical_factor ||
        got.group_rows != want.group_rows ||
        got.group_cols != want.group_cols) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch at result %0d", checked);
        show("  expected", want);
        show("  actual  ", got);
      end
    end
  endfunction
endclass

module tb_image_header_field_parser;

  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef enum int {
    F_WIDTH, F_HEIGHT, F_COMP, F_FRAME, F_PLAIN, F_DELIM, F_BADTAG
  } field_pick_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [RESULT_W-1:0]   m_tdata;

  header_result_board sb;
  bit                 tx_idle;
  bit                 rx_idle;
  bit                 hold_req;
  int unsigned        bytes_sent;
  int unsigned        headers_sent;
  int unsigned        settings;
  logic [7:0]         cur_marker;
  logic [7:0]         body[$];
  logic [7:0]         hdr[$];
  field_pick_t        picks[$];

  image_header_field_parser u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("tb_image_header_field_parser failed");
    $finish;
  end

  // result side: check each transfer, then pick next tready
  initial begin : receive
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready) sb.check_result(m_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 13);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] pick_size();
    case ($urandom_range(0, 19))
      0: return 64'd0;
      1: return 64'd1;
      2: return 64'hFFFF;
      3: return 64'h10000 + $urandom_range(0, 1000);
      4: return {$urandom, $urandom} >> $urandom_range(0, 48);
      5, 6: return $urandom_range(1, 65535);
      default: return $urandom_range(1, 3000);
    endcase
  endfunction

  function automatic logic [63:0] pick_comp();
    case ($urandom_range(0, 15))
      0: return $urandom_range(8, 255);
      1: return $urandom_range(256, 70000);
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  function automatic logic [63:0] pick_frame();
    case ($urandom_range(0, 11))
      0: return 64'hFF;
      1: return {$urandom, $urandom} >> $urandom_range(0, 31);
      2: return 64'd0;
      default: return {32'd0, $urandom};
    endcase
  endfunction

  function automatic int unsigned pick_pad();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
  endfunction

  // base-128 encoding, optionally padded with redundant zero groups
  function automatic void put_varint(bit to_body, logic [63:0] v, int unsigned pad);
    int unsigned n, total;
    logic [63:0] part;
    logic [7:0] b;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 0) n++;
    total = n + pad;
    for (int i = 0; i < total; i++) begin
      part = v >> (7 * i);
      b = {(i != total - 1), part[6:0]};
      if (to_body) body.push_back(b);
      else hdr.push_back(b);
    end
  endfunction

  task automatic make_header();
    field_pick_t t;
    int unsigned j, n, stated;
    logic [63:0] seg_len;
    body.delete();
    hdr.delete();
    picks.delete();
    if ($urandom_range(0, 9) != 0) picks.push_back(F_WIDTH);
    if ($urandom_range(0, 9) != 0) picks.push_back(F_HEIGHT);
    if ($urandom_range(0, 9) != 0) picks.push_back(F_COMP);
    if ($urandom_range(0, 9) != 0) picks.push_back(F_FRAME);
    repeat ($urandom_range(0, 2)) picks.push_back($urandom_range(0, 1) ? F_PLAIN : F_DELIM);
    if ($urandom_range(0, 19) == 0) picks.push_back(field_pick_t'($urandom_range(0, 3)));
    if ($urandom_range(0, 29) == 0) picks.push_back(F_BADTAG);
    for (int i = picks.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = picks[i];
      picks[i] = picks[j];
      picks[j] = t;
    end
    foreach (picks[k]) begin
      case (picks[k])
        F_WIDTH: begin
          body.push_back(TAG_WIDTH);
          put_varint(1, pick_size(), pick_pad());
        end
        F_HEIGHT: begin
          body.push_back(TAG_HEIGHT);
          put_varint(1, pick_size(), pick_pad());
        end
        F_COMP: begin
          body.push_back(TAG_COMP);
          put_varint(1, pick_comp(), pick_pad());
        end
        F_FRAME: begin
          body.push_back(TAG_FRAME);
          put_varint(1, pick_frame(), pick_pad());
        end
        F_PLAIN: begin
          body.push_back(8'($urandom_range(5, 15) << 3));
          put_varint(1, {$urandom, $urandom} >> $urandom_range(1, 63), pick_pad());
        end
        F_DELIM: begin
          body.push_back({1'b0, 4'($urandom_range(1, 15)), WIRE_DELIM});
          n = $urandom_range(0, 5);
          stated = ($urandom_range(0, 14) == 0) ? n + $urandom_range(1, 300) : n;
          put_varint(1, stated, 0);
          repeat (n) body.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          case ($urandom_range(0, 3))
            0: body.push_back(8'($urandom_range(128, 255)));
            1: body.push_back(8'($urandom_range(0, 2)));
            2: body.push_back(8'($urandom_range(0, 127)) | 8'h01);
            default: body.push_back(8'($urandom_range(0, 127)) | 8'h04);
          endcase
          body.push_back(8'($urandom_range(0, 127)));
        end
      endcase
    end
    case ($urandom_range(0, 19))
      0: seg_len = body.size() + 1;
      1: seg_len = (body.size() > 0) ? body.size() - 1 : 0;
      2: seg_len = {$urandom, $urandom} >> $urandom_range(0, 40);
      3: seg_len = 0;
      default: seg_len = body.size();
    endcase
    hdr.push_back(($urandom_range(0, 14) == 0) ? cur_marker ^ 8'($urandom_range(1, 255))
                                                : cur_marker);
    if ($urandom_range(0, 39) == 0) repeat (10) hdr.push_back(8'($urandom_range(128, 255)));
    else put_varint(0, seg_len, pick_pad());
    foreach (body[k]) hdr.push_back(body[k]);
    repeat ($urandom_range(0, 2)) hdr.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic restart);
    int unsigned gap;
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= restart;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.note_byte(b, restart);
    bytes_sent++;
  endtask

  task automatic send_header();
    make_header();
    foreach (hdr[k])
      send_byte(hdr[k], (k == 0) ? ($urandom_range(0, 29) != 0) : ($urandom_range(0, 49) == 0));
    headers_sent++;
  endtask

  task automatic run_headers(input int unsigned budget, input bit idling);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      tx_idle = idling && ($urandom_range(0, 3) != 0);
      rx_idle = idling && ($urandom_range(0, 3) != 0);
      send_header();
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] len, input logic [7:0] mk);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_STREAM_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    cfg_index <= REG_MARKER;
    cfg_data <= {24'd0, mk};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(REG_STREAM_LENGTH, len);
    sb.set_reg(REG_MARKER, {24'd0, mk});
    cur_marker = mk;
    settings++;
  endtask

  initial begin
    sb = new();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_req = 1'b0;
    bytes_sent = 0;
    headers_sent = 0;
    settings = 0;
    cur_marker = 8'h0A;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: zero stream length, then a sticky byte
    send_byte(8'h0A, 1'b1);
    send_byte(8'h00, 1'b0);

    set_regs(32'hFFFF_FFFF, 8'h0A);
    // full-size width, four components, all factors at 16, then a sticky byte
    send_byte(8'h0A, 1'b1); send_byte(8'h0E, 1'b0);
    send_byte(TAG_WIDTH, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(TAG_HEIGHT, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(TAG_COMP, 1'b0); send_byte(8'h03, 1'b0);
    send_byte(TAG_FRAME, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h0F, 1'b0);
    send_byte(8'h00, 1'b0);
    // wrong marker
    send_byte(8'h0B, 1'b1);
    // empty segment
    send_byte(8'h0A, 1'b1); send_byte(8'h00, 1'b0);
    // version 1 without sizes
    send_byte(8'h0A, 1'b1); send_byte(8'h04, 1'b0);
    send_byte(TAG_COMP, 1'b0); send_byte(8'h04, 1'b0);
    send_byte(TAG_FRAME, 1'b0); send_byte(8'h00, 1'b0);

    hold_req = 1'b1;
    run_headers(300, 1'b1);
    set_regs(32'd1000, 8'h00);
    run_headers(250, 1'b1);
    set_regs(32'($urandom_range(6, 40)), 8'hFF);
    run_headers(200, 1'b1);
    set_regs(32'd0, 8'($urandom_range(0, 255)));
    run_headers(20, 1'b1);
    set_regs(32'hFFFF_FFFF, 8'($urandom_range(0, 255)));
    run_headers(250, 1'b0);
    drain();

    $display("covered %0d stream bytes in %0d headers across %0d register settings",
             bytes_sent, headers_sent, settings);
    $display("%0d results checked: %0d complete headers, %0d error results, %0d mismatches",
             sb.checked, sb.n_done, sb.n_err, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_image_header_field_parser passed");
    end else begin
      $display("tb_image_header_field_parser failed");
    end
    $finish;
  end

endmodule
